// ----- src/hilbert_fir_filter_top_assert.svh -----
`ifndef HILBERT_FIR_FILTER_TOP_ASSERT_SVH
`define HILBERT_FIR_FILTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define HFIR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HFIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/hfir_pkg.sv -----
package hfir_pkg;

   localparam int ORDER       = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 18;

   localparam int NTAPS      = ORDER + 1;
   localparam int HALF       = ORDER / 2;
   localparam int COEF_FRAC  = COEF_BITS - 2;
   localparam int NPAIR      = (HALF + 1) / 2;
   localparam int ADDR_BITS  = $clog2(NTAPS);
   localparam int PAIR_BITS  = (NPAIR > 1) ? $clog2(NPAIR) : 1;
   localparam int DIFF_BITS  = SAMPLE_BITS + 1;
   localparam int DIGIT_BITS = 6;
   localparam int NDIG       = (DIFF_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int DEXT_BITS  = NDIG * DIGIT_BITS;
   localparam int DIG_BITS   = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int PP_BITS    = COEF_BITS + DIGIT_BITS + 1;
   localparam int PROD_BITS  = COEF_BITS + DEXT_BITS;
   localparam int ACC_BITS   = PROD_BITS + $clog2(NPAIR + 1);
   localparam int RND_BITS   = ACC_BITS + 1;
   localparam int YQ_BITS    = RND_BITS - COEF_FRAC;
   localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int ROUND_HALF = 2 ** (COEF_FRAC - 1);

   localparam longint          ONE_Q30     = longint'(1) << 30;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam longint          C054_Q30    = 64'sd579820585;
   localparam longint          C046_Q30    = 64'sd493921239;

   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic [ADDR_BITS:0]            addr_w1_type;
   typedef logic [PAIR_BITS-1:0]          pair_type;
   typedef logic [DIG_BITS-1:0]           dig_type;
   typedef logic [SAMPLE_BITS-1:0]        sample_type;
   typedef logic [TDATA_BITS-1:0]         tdata_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [DIFF_BITS-1:0]   diff_type;
   typedef logic signed [DEXT_BITS-1:0]   dext_type;
   typedef logic signed [PP_BITS-1:0]     pp_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef logic signed [RND_BITS-1:0]    rnd_type;
   typedef logic [YQ_BITS-1:0]            yq_type;
   typedef coef_type                      coef_rom_type [NPAIR];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL,
      ST_FLUSH,
      ST_ROUND
   } state_type;

   typedef struct packed {
      logic     we;
      addr_type waddr;
      logic     re;
      addr_type raddr_a;
      addr_type raddr_b;
   } mem_ctl_type;

   typedef struct packed {
      logic     clear;
      logic     load;
      logic     step;
      logic     last;
      coef_type coef;
   } mac_ctl_type;

   // Unsigned 64-bit quotient by shift and subtract, elaboration time only.
   function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Positive tap magnitudes, one per odd offset a = 2*i+1 from the centre.
   function automatic coef_rom_type build_coef_rom();
      coef_rom_type    rom;
      longint          hq [NPAIR];
      longint          gain;
      longint          lim;
      longint          sum;
      longint          cv;
      longint          sv;
      longint          cs;
      longint          w60;
      longint          w30;
      longint          m;
      longint unsigned a;
      longint unsigned p;
      longint unsigned q;
      longint unsigned quad;
      longint unsigned r;
      longint unsigned th;
      longint unsigned th2;
      longint unsigned t;
      longint unsigned k;
      gain = 0;
      lim  = (longint'(1) << (COEF_BITS - 1)) - 1;
      for (int i = 0; i < NPAIR; i++) begin
         a    = $unsigned(longint'(2 * i + 1));
         p    = $unsigned(longint'(HALF)) + a;
         q    = 4 * (p % ORDER);
         quad = q / ORDER;
         r    = q % ORDER;
         th   = (PI_HALF_Q30 * r + ORDER / 2) / ORDER;
         th2  = (th * th) >> 30;
         t    = $unsigned(ONE_Q30);
         k    = 1;
         sum  = 0;
         for (int n = 0; n < 10; n++) begin
            if (n % 2 == 1) sum = sum - $signed(t);
            else sum = sum + $signed(t);
            t = div_u64((t * th2) >> 30, k * (k + 1));
            k = k + 2;
         end
         cv  = sum;
         t   = th;
         k   = 2;
         sum = 0;
         for (int n = 0; n < 10; n++) begin
            if (n % 2 == 1) sum = sum - $signed(t);
            else sum = sum + $signed(t);
            t = div_u64((t * th2) >> 30, k * (k + 1));
            k = k + 2;
         end
         sv = sum;
         case (quad)
            0: cs = cv;
            1: cs = -sv;
            2: cs = -cv;
            default: cs = sv;
         endcase
         w60 = C054_Q30 * ONE_Q30 - C046_Q30 * cs;
         if (w60 < 0) w60 = 0;
         w30   = $signed(($unsigned(w60) + (64'd1 << 29)) >> 30);
         hq[i] = $signed(div_u64($unsigned(w30) + (a >> 1), a));
         if ((a & 64'd3) == 64'd1) gain = gain + hq[i];
         else gain = gain - hq[i];
      end
      gain = gain * 2;
      if (gain <= 0) gain = 1;
      for (int i = 0; i < NPAIR; i++) begin
         m = $signed(div_u64(($unsigned(hq[i]) << COEF_FRAC) + $unsigned(gain >>> 1),
                             $unsigned(gain)));
         if (m > lim) m = lim;
         rom[i] = coef_type'(m);
      end
      return rom;
   endfunction

   localparam coef_rom_type COEF_ROM = build_coef_rom();

endpackage

// ----- src/hfir_delay_mem.sv -----
module hfir_delay_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  hfir_pkg::mem_ctl_type ctl,
   input  hfir_pkg::sample_type wdata,
   output hfir_pkg::sample_type rdata_a,
   output hfir_pkg::sample_type rdata_b
);

   hfir_pkg::sample_type         mem_ff [hfir_pkg::NTAPS];
   hfir_pkg::sample_type         q_a_ff;
   hfir_pkg::sample_type         q_b_ff;
   logic [hfir_pkg::NTAPS-1:0]   valid_ff;
   logic                         va_ff;
   logic                         vb_ff;

   // Storage and read data: no reset.
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem_ff[ctl.waddr] <= wdata;
      end
      if (ctl.re) begin
         q_a_ff <= mem_ff[ctl.raddr_a];
         q_b_ff <= mem_ff[ctl.raddr_b];
      end
   end

   // Per-entry valid bits; an unwritten entry reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
      end else begin
         if (ctl.we) begin
            valid_ff[ctl.waddr] <= 1'b1;
         end
         if (ctl.re) begin
            va_ff <= valid_ff[ctl.raddr_a];
            vb_ff <= valid_ff[ctl.raddr_b];
         end
      end
   end

   assign rdata_a = va_ff ? q_a_ff : '0;
   assign rdata_b = vb_ff ? q_b_ff : '0;

endmodule

// ----- src/hfir_digit_mac.sv -----
module hfir_digit_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  hfir_pkg::mac_ctl_type ctl,
   input  hfir_pkg::sample_type  sample_a,
   input  hfir_pkg::sample_type  sample_b,
   output hfir_pkg::acc_type     acc
);

   hfir_pkg::diff_type              diff;
   hfir_pkg::dext_type              diff_ext;
   logic [hfir_pkg::DEXT_BITS-1:0]  sr_ff;
   logic [hfir_pkg::DEXT_BITS-1:0]  sr_in;
   hfir_pkg::coef_type              coef_ff;
   hfir_pkg::coef_type              coef_in;
   hfir_pkg::coef_type              coef_sel;
   logic signed [hfir_pkg::DIGIT_BITS:0] digit;
   hfir_pkg::pp_type                pp;
   hfir_pkg::prod_type              prod_ff;
   hfir_pkg::prod_type              prod_in;
   logic                            done_ff;
   logic                            done_in;
   hfir_pkg::acc_type               acc_ff;
   hfir_pkg::acc_type               acc_in;

   // Antisymmetric pair: m*x[centre-a] - m*x[centre+a] = m*(difference).
   assign diff     = hfir_pkg::diff_type'($signed(sample_a))
                   - hfir_pkg::diff_type'($signed(sample_b));
   assign diff_ext = hfir_pkg::dext_type'(diff);

   // Horner, most significant digit first; top digit signed, rest unsigned.
   always_comb begin
      coef_sel = ctl.load ? ctl.coef : coef_ff;
      if (ctl.load) begin
         digit = {diff_ext[hfir_pkg::DEXT_BITS-1],
                  diff_ext[hfir_pkg::DEXT_BITS-1 -: hfir_pkg::DIGIT_BITS]};
      end else begin
         digit = {1'b0, sr_ff[hfir_pkg::DEXT_BITS-1 -: hfir_pkg::DIGIT_BITS]};
      end
      pp = coef_sel * digit;

      sr_in   = sr_ff;
      coef_in = coef_ff;
      prod_in = prod_ff;
      done_in = (ctl.load | ctl.step) & ctl.last;
      if (ctl.load) begin
         sr_in   = diff_ext << hfir_pkg::DIGIT_BITS;
         coef_in = ctl.coef;
         prod_in = hfir_pkg::prod_type'(pp);
      end else if (ctl.step) begin
         sr_in   = sr_ff << hfir_pkg::DIGIT_BITS;
         prod_in = (prod_ff <<< hfir_pkg::DIGIT_BITS) + hfir_pkg::prod_type'(pp);
      end

      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (done_ff) begin
         acc_in = acc_ff + hfir_pkg::acc_type'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      sr_ff   <= sr_in;
      coef_ff <= coef_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
         acc_ff  <= '0;
      end else begin
         done_ff <= done_in;
         acc_ff  <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ----- src/hfir_ctrl.sv -----
`include "hilbert_fir_filter_top_assert.svh"

module hfir_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_free,
   output logic                  ready,
   output logic                  out_load,
   output hfir_pkg::mem_ctl_type mem,
   output hfir_pkg::mac_ctl_type mac
);

   hfir_pkg::state_type   state_ff;
   hfir_pkg::state_type   state_in;
   hfir_pkg::addr_type    wp_ff;
   hfir_pkg::addr_type    wp_in;
   hfir_pkg::pair_type    pair_ff;
   hfir_pkg::pair_type    pair_in;
   hfir_pkg::dig_type     dig_ff;
   hfir_pkg::dig_type     dig_in;
   hfir_pkg::pair_type    rd_pair;
   hfir_pkg::addr_w1_type off_a;
   hfir_pkg::addr_w1_type off_b;
   hfir_pkg::addr_w1_type sum_a;
   hfir_pkg::addr_w1_type sum_b;
   logic                  last_pair;
   logic                  last_dig;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hfir_pkg::ST_IDLE;
         wp_ff    <= '0;
         pair_ff  <= '0;
         dig_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         pair_ff  <= pair_in;
         dig_ff   <= dig_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      pair_in  = pair_ff;
      dig_in   = dig_ff;
      ready    = 1'b0;
      out_load = 1'b0;

      last_pair = (pair_ff == hfir_pkg::pair_type'(hfir_pkg::NPAIR - 1));
      last_dig  = (dig_ff == hfir_pkg::dig_type'(hfir_pkg::NDIG - 1));

      // Tap pair to fetch: oldest sample sits at the write pointer.
      rd_pair = (state_ff == hfir_pkg::ST_FETCH) ? '0 : pair_ff + hfir_pkg::pair_type'(1);
      off_a   = hfir_pkg::addr_w1_type'(hfir_pkg::HALF - 1)
              - hfir_pkg::addr_w1_type'({rd_pair, 1'b0});
      off_b   = hfir_pkg::addr_w1_type'(hfir_pkg::HALF + 1)
              + hfir_pkg::addr_w1_type'({rd_pair, 1'b0});
      sum_a   = hfir_pkg::addr_w1_type'(wp_ff) + off_a;
      sum_b   = hfir_pkg::addr_w1_type'(wp_ff) + off_b;

      mem.we    = 1'b0;
      mem.waddr = wp_ff;
      mem.re    = 1'b0;
      mem.raddr_a = (sum_a >= hfir_pkg::addr_w1_type'(hfir_pkg::NTAPS))
                  ? hfir_pkg::addr_type'(sum_a - hfir_pkg::addr_w1_type'(hfir_pkg::NTAPS))
                  : hfir_pkg::addr_type'(sum_a);
      mem.raddr_b = (sum_b >= hfir_pkg::addr_w1_type'(hfir_pkg::NTAPS))
                  ? hfir_pkg::addr_type'(sum_b - hfir_pkg::addr_w1_type'(hfir_pkg::NTAPS))
                  : hfir_pkg::addr_type'(sum_b);

      mac.clear = 1'b0;
      mac.load  = 1'b0;
      mac.step  = 1'b0;
      mac.last  = 1'b0;
      mac.coef  = hfir_pkg::COEF_ROM[pair_ff];

      case (state_ff)
         hfir_pkg::ST_IDLE: begin
            ready = 1'b1;
            if (req_valid) begin
               mem.we    = 1'b1;
               mac.clear = 1'b1;
               wp_in     = (wp_ff == hfir_pkg::addr_type'(hfir_pkg::NTAPS - 1))
                         ? '0 : wp_ff + hfir_pkg::addr_type'(1);
               pair_in   = '0;
               dig_in    = '0;
               state_in  = hfir_pkg::ST_FETCH;
            end
         end
         hfir_pkg::ST_FETCH: begin
            mem.re   = 1'b1;
            state_in = hfir_pkg::ST_MUL;
         end
         hfir_pkg::ST_MUL: begin
            if (dig_ff == '0) begin
               mac.load = 1'b1;
               mem.re   = !last_pair;
            end else begin
               mac.step = 1'b1;
            end
            if (last_dig) begin
               mac.last = 1'b1;
               dig_in   = '0;
               if (last_pair) begin
                  state_in = hfir_pkg::ST_FLUSH;
               end else begin
                  pair_in = pair_ff + hfir_pkg::pair_type'(1);
               end
            end else begin
               dig_in = dig_ff + hfir_pkg::dig_type'(1);
            end
         end
         hfir_pkg::ST_FLUSH: begin
            state_in = hfir_pkg::ST_ROUND;
         end
         hfir_pkg::ST_ROUND: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = hfir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hfir_pkg::ST_IDLE;
         end
      endcase
   end

   `HFIR_ASSERT_NOW(a_no_rw_clash, clock, reset, mem.we, !mem.re, "delay line written and read together")
   `HFIR_ASSERT_NOW(a_raddr_range, clock, reset, mem.re, (32'(mem.raddr_a) < hfir_pkg::NTAPS) && (32'(mem.raddr_b) < hfir_pkg::NTAPS), "read address beyond delay line")
   `HFIR_ASSERT_NEXT(a_last_flush, clock, reset, mac.last && last_pair, state_ff == hfir_pkg::ST_FLUSH, "last product not flushed")
   `HFIR_ASSERT_NEXT(a_busy_after_accept, clock, reset, mem.we, !ready && (dig_ff == '0) && (pair_ff == '0), "sequencer not restarted on transaction")

endmodule

// ----- src/hilbert_fir_filter_top.sv -----
// Hilbert-transform FIR, 65 taps, one sample in and one sample out per transaction.
// The antisymmetric odd taps are folded into 16 pre-subtracted pairs, and each pair
// goes through a digit-serial multiplier that takes 6 bits of the difference per cycle,
// so three digits per pair. A sample passes through these steps, in order, before the
// next one is accepted: accept, delay-line fetch, multiply, accumulate, round and
// saturate, where the round step waits until the output register is free; the result is
// then registered on the output. A new sample may be accepted while the previous result
// still waits on the output. The delay line starts cleared straight out of reset through
// per-entry valid bits, with no clearing pass.
module hilbert_fir_filter_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  hfir_pkg::tdata_type req_tdata,   // [15:0] sample_in
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output hfir_pkg::tdata_type rsp_tdata    // [15:0] sample_out
);

   hfir_pkg::mem_ctl_type mem_ctl;
   hfir_pkg::mac_ctl_type mac_ctl;
   hfir_pkg::sample_type  rdata_a;
   hfir_pkg::sample_type  rdata_b;
   hfir_pkg::acc_type     acc;
   logic                  ready;
   logic                  out_load;
   logic                  out_free;
   hfir_pkg::rnd_type     rnd;
   hfir_pkg::yq_type      yq;
   logic [hfir_pkg::YQ_BITS-hfir_pkg::SAMPLE_BITS:0] upper;
   logic                  in_range;
   hfir_pkg::sample_type  y;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   hfir_pkg::sample_type  rsp_data_ff;
   hfir_pkg::sample_type  rsp_data_in;

   hfir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .ready     (ready),
      .out_load  (out_load),
      .mem       (mem_ctl),
      .mac       (mac_ctl)
   );

   hfir_delay_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wdata   (req_tdata[hfir_pkg::SAMPLE_BITS-1:0]),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   hfir_digit_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .sample_a (rdata_a),
      .sample_b (rdata_b),
      .acc      (acc)
   );

   assign req_tready = ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Round half up, floor shift, saturate.
   always_comb begin
      rnd      = hfir_pkg::rnd_type'(acc) + hfir_pkg::rnd_type'(hfir_pkg::ROUND_HALF);
      yq       = rnd[hfir_pkg::RND_BITS-1:hfir_pkg::COEF_FRAC];
      upper    = yq[hfir_pkg::YQ_BITS-1:hfir_pkg::SAMPLE_BITS-1];
      in_range = (&upper) || !(|upper);
      if (in_range) begin
         y = yq[hfir_pkg::SAMPLE_BITS-1:0];
      end else if (yq[hfir_pkg::YQ_BITS-1]) begin
         y = {1'b1, {(hfir_pkg::SAMPLE_BITS-1){1'b0}}};
      end else begin
         y = {1'b0, {(hfir_pkg::SAMPLE_BITS-1){1'b1}}};
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = y;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = hfir_pkg::tdata_type'(rsp_data_ff);

endmodule

// ----- verif/hilbert_fir_filter_checker.sv -----
`timescale 1ns / 100ps

module hilbert_fir_filter_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  hfir_pkg::tdata_type req_tdata,   // [15:0] sample_in
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  hfir_pkg::tdata_type rsp_tdata,   // [15:0] sample_out
   output int                  fail_count,
   output int                  pending_count,
   output int                  sample_count,
   output int                  result_count
);

   localparam int NTAPS     = hfir_pkg::NTAPS;
   localparam int HALF      = hfir_pkg::HALF;
   localparam int ORDER     = hfir_pkg::ORDER;
   localparam int SBITS     = hfir_pkg::SAMPLE_BITS;
   localparam int COEF_FRAC = hfir_pkg::COEF_BITS - 2;

   localparam longint          Q30_ONE     = longint'(1) << 30;
   localparam longint unsigned QUARTER_PI2 = 64'd1686629713;
   localparam longint          HAMMING_A   = 64'sd579820585;
   localparam longint          HAMMING_B   = 64'sd493921239;

   longint             tap_weight  [NTAPS];
   longint             held_sample [NTAPS];
   int                 write_index;
   hfir_pkg::tdata_type filtered_queue [$];
   int                 mismatches;
   int                 accepted;
   int                 delivered;

   function automatic longint taylor_q30(longint unsigned first, longint unsigned th2,
                                         longint unsigned k0);
      longint          sum;
      longint unsigned t;
      longint unsigned k;
      sum = 0;
      t   = first;
      k   = k0;
      for (int n = 0; n < 10; n++) begin
         if (n % 2 == 1) sum = sum - longint'(t);
         else sum = sum + longint'(t);
         t = ((t * th2) >> 30) / (k * (k + 1));
         k = k + 2;
      end
      return sum;
   endfunction

   // Hamming window at odd offset a from the centre, divided by a, in Q30.
   function automatic longint windowed_reciprocal_q30(longint unsigned a);
      longint unsigned p;
      longint unsigned q;
      longint unsigned quad;
      longint unsigned r;
      longint unsigned th;
      longint unsigned th2;
      longint          c;
      longint          s;
      longint          cs;
      longint          w60;
      longint          w30;
      p    = longint'(HALF) + a;
      q    = 4 * (p % ORDER);
      quad = q / ORDER;
      r    = q % ORDER;
      th   = (QUARTER_PI2 * r + ORDER / 2) / ORDER;
      th2  = (th * th) >> 30;
      c    = taylor_q30(Q30_ONE, th2, 1);
      s    = taylor_q30(th, th2, 2);
      case (quad)
         0: cs = c;
         1: cs = -s;
         2: cs = -c;
         default: cs = s;
      endcase
      w60 = HAMMING_A * Q30_ONE - HAMMING_B * cs;
      if (w60 < 0) w60 = 0;
      w30 = (w60 + (longint'(1) << 29)) >>> 30;
      return (w30 + longint'(a / 2)) / longint'(a);
   endfunction

   initial begin : build_taps
      longint gain;
      longint mag;
      longint limit;
      gain  = 0;
      limit = (longint'(1) << (hfir_pkg::COEF_BITS - 1)) - 1;
      for (int k = 0; k < NTAPS; k++) tap_weight[k] = 0;
      for (int a = 1; a <= HALF; a += 2) begin
         if (a % 4 == 1) gain = gain + windowed_reciprocal_q30(a);
         else gain = gain - windowed_reciprocal_q30(a);
      end
      gain = gain * 2;
      if (gain <= 0) gain = 1;
      for (int a = 1; a <= HALF; a += 2) begin
         mag = ((windowed_reciprocal_q30(a) << COEF_FRAC) + gain / 2) / gain;
         if (mag > limit) mag = limit;
         tap_weight[HALF + a] = -mag;
         tap_weight[HALF - a] = mag;
      end
   end

   always @(posedge clock) begin : monitor
      longint              acc;
      longint              y;
      longint              top;
      int                  idx;
      hfir_pkg::tdata_type want;
      if (reset) begin
         for (int k = 0; k < NTAPS; k++) held_sample[k] = 0;
         write_index = 0;
         filtered_queue.delete();
         mismatches = 0;
         accepted   = 0;
         delivered  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            delivered++;
            if (filtered_queue.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected output transaction, sample_out %h",
                           $realtime, rsp_tdata);
               mismatches++;
            end else begin
               want = filtered_queue.pop_front();
               if (rsp_tdata !== want) begin
                  if (mismatches < 10)
                     $display("%0t: sample_out mismatch, expected %h got %h",
                              $realtime, want, rsp_tdata);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            accepted++;
            held_sample[write_index] = $signed(req_tdata[SBITS-1:0]);
            write_index = (write_index + 1 == NTAPS) ? 0 : write_index + 1;
            idx = write_index;
            acc = 0;
            for (int k = 0; k < NTAPS; k++) begin
               acc = acc + held_sample[idx] * tap_weight[k];
               idx = (idx + 1 == NTAPS) ? 0 : idx + 1;
            end
            acc = acc + (longint'(1) << (COEF_FRAC - 1));
            y   = acc >>> COEF_FRAC;
            top = (longint'(1) << (SBITS - 1)) - 1;
            if (y > top) y = top;
            if (y < -top - 1) y = -top - 1;
            want = '0;
            want[SBITS-1:0] = y[SBITS-1:0];
            filtered_queue.push_back(want);
         end
      end
      fail_count    <= mismatches;
      pending_count <= filtered_queue.size();
      sample_count  <= accepted;
      result_count  <= delivered;
   end

endmodule

// ----- verif/hilbert_fir_filter_top_tb.sv -----
`timescale 1ns / 100ps

module hilbert_fir_filter_top_tb;

   typedef enum int {
      PH_STREAM,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE,
      PH_COUNT
   } phase_type;

   typedef enum int {
      SEG_UNIFORM,
      SEG_QUIET,
      SEG_STEP,
      SEG_TONE,
      SEG_EXTREME,
      SEG_COUNT
   } segment_type;

   localparam int                   ITEMS_PER_PHASE = 225;
   localparam hfir_pkg::sample_type POS_FULL        = 16'h7FFF;
   localparam hfir_pkg::sample_type NEG_FULL        = 16'h8000;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   hfir_pkg::tdata_type req_tdata  = '0;   // [15:0] sample_in
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   hfir_pkg::tdata_type rsp_tdata;         // [15:0] sample_out

   int fail_count;
   int pending_count;
   int sample_count;
   int result_count;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   hilbert_fir_filter_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hilbert_fir_filter_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .sample_count  (sample_count),
      .result_count  (result_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_sample(input hfir_pkg::sample_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= hfir_pkg::tdata_type'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // One burst of related samples; returns how many were sent.
   task automatic send_segment(output int sent);
      segment_type          kind;
      int                   len;
      int                   amp;
      int                   ph;
      logic                 flip;
      hfir_pkg::sample_type v;
      kind = segment_type'($urandom_range(SEG_COUNT - 1));
      sent = 0;
      case (kind)
         SEG_STEP: begin
            flip = 1'($urandom_range(1));
            len  = $urandom_range(16, 40);
            for (int i = 0; i < len; i++) send_sample(flip ? NEG_FULL : POS_FULL);
            sent = len;
            len  = $urandom_range(16, 40);
            for (int i = 0; i < len; i++) send_sample(flip ? POS_FULL : NEG_FULL);
            sent = sent + len;
         end
         SEG_TONE: begin
            amp = $urandom_range(1, 32767);
            ph  = $urandom_range(3);
            len = $urandom_range(16, 48);
            for (int i = 0; i < len; i++) begin
               case ((i + ph) % 4)
                  0, 2: v = '0;
                  1: v = hfir_pkg::sample_type'(amp);
                  default: v = hfir_pkg::sample_type'(-amp);
               endcase
               send_sample(v);
            end
            sent = len;
         end
         default: begin
            len = $urandom_range(4, 32);
            for (int i = 0; i < len; i++) begin
               if (kind == SEG_QUIET)
                  v = hfir_pkg::sample_type'($urandom_range(510) - 255);
               else if (kind == SEG_EXTREME)
                  case ($urandom_range(3))
                     0: v = POS_FULL;
                     1: v = NEG_FULL;
                     2: v = '0;
                     default: v = '1;
                  endcase
               else
                  v = hfir_pkg::sample_type'($urandom_range(16'hFFFF));
               send_sample(v);
            end
            sent = len;
         end
      endcase
   endtask

   initial begin : stimulus
      int sent;
      int count;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample('0);
      send_sample(POS_FULL);
      send_sample(NEG_FULL);
      send_sample('1);
      send_sample(16'h0001);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      for (int i = 0; i < 8; i++) send_sample(POS_FULL);
      for (int i = 0; i < 8; i++) send_sample(NEG_FULL);

      for (int p = 0; p < PH_COUNT; p++) begin
         case (phase_type'(p))
            PH_STREAM:         begin send_idle_pct = 0;  stall_pct = 0;  end
            PH_SENDER_IDLE:    begin send_idle_pct = 65; stall_pct = 0;  end
            PH_RECEIVER_STALL: begin send_idle_pct = 0;  stall_pct = 65; end
            default:           begin send_idle_pct = 15; stall_pct = 15; end
         endcase
         count = 0;
         while (count < ITEMS_PER_PHASE) begin
            send_segment(sent);
            count = count + sent;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Filtered %0d input samples and checked %0d outputs: extremes, full-scale steps,",
               sample_count, result_count);
      $display("quarter-rate tones and quiet noise, with free-running, idle and stalled handshakes.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("hilbert_fir_filter_top: match");
      end else begin
         $display("hilbert_fir_filter_top: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("hilbert_fir_filter_top: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/hfir_pkg.sv
src/hfir_delay_mem.sv
src/hfir_digit_mac.sv
src/hfir_ctrl.sv
src/hilbert_fir_filter_top.sv
verif/hilbert_fir_filter_checker.sv
verif/hilbert_fir_filter_top_tb.sv
